/* design/sobol_sequence_generator_top_macros.svh */
// Assertion macros used by the Sobol generator checker.
// Expects signals clk and rst_n in the scope of each use.
`ifndef SOBOL_SEQUENCE_GENERATOR_TOP_MACROS_SVH
`define SOBOL_SEQUENCE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset
`define SOBOL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobol_gen: assertion failed");

// Next-cycle implication, quiet during reset
`define SOBOL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobol_gen: assertion failed");

// Check the cycle after reset is sampled low
`define SOBOL_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("sobol_gen: assertion failed");

`endif

/* design/sobol_gen_pkg.sv */
// Types, constants and the direction-number ROM for the Sobol generator.
// No dependencies; the cfg, core and top design files refer to it by scoped names.
package sobol_gen_pkg;

  localparam int MAX_DIMS      = 8;
  localparam int FRACTION_BITS = 32;
  localparam int DIR_IDX_W     = $clog2(FRACTION_BITS);
  localparam int DIMS_W        = 4;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic REG_DIMS    = 1'b0;
  localparam logic REG_RUN_LEN = 1'b1;

  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef frac_t [MAX_DIMS-1:0][FRACTION_BITS-1:0] dir_rom_t;

  typedef struct packed {
    logic [DIMS_W-1:0] dims_in_use;
    logic [31:0]       points_per_run;
  } cfg_t;

  typedef struct packed {
    logic [31:0]              point_index;
    logic                     last_point;
    frac_t [MAX_DIMS-1:0]     coord;
  } point_t;

  localparam int POLY_DEG [MAX_DIMS] = '{0, 1, 2, 3, 3, 4, 4, 5};
  localparam int POLY_A   [MAX_DIMS] = '{0, 0, 1, 1, 2, 1, 4, 2};
  localparam int POLY_INIT [MAX_DIMS][5] = '{
    '{1, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0},
    '{1, 3, 0, 0, 0},
    '{1, 3, 1, 0, 0},
    '{1, 1, 1, 0, 0},
    '{1, 1, 3, 3, 0},
    '{1, 3, 5, 13, 0},
    '{1, 1, 5, 5, 17}
  };

  // Entry [d][k] is direction number k+1 of dimension d
  function automatic dir_rom_t build_dir_rom();
    dir_rom_t rom;
    frac_t    w [FRACTION_BITS+1];
    frac_t    v;
    int       s;
    int       a;
    rom = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      s = POLY_DEG[d];
      a = POLY_A[d];
      for (int i = 0; i <= FRACTION_BITS; i++) w[i] = '0;
      if (d == 0) begin
        for (int i = 1; i <= FRACTION_BITS; i++)
          w[i] = frac_t'(1) << (FRACTION_BITS - i);
      end else begin
        for (int i = 1; i <= s; i++)
          w[i] = frac_t'(POLY_INIT[d][i-1]) << (FRACTION_BITS - i);
        for (int i = s + 1; i <= FRACTION_BITS; i++) begin
          v = w[i-s] ^ (w[i-s] >> s);
          for (int j = 1; j + 1 <= s; j++) begin
            if (((a >> (s - 1 - j)) & 1) != 0) v = v ^ w[i-j];
          end
          w[i] = v;
        end
      end
      for (int i = 1; i <= FRACTION_BITS; i++) rom[d][i-1] = w[i];
    end
    return rom;
  endfunction

  localparam dir_rom_t DIR_ROM = build_dir_rom();

endpackage

/* design/sobol_gen_cfg.sv */
// APB-style configuration registers: active dimension count and run length.
// Depends on sobol_gen_pkg.
module sobol_gen_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sobol_gen_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sobol_gen_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sobol_gen_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output sobol_gen_pkg::cfg_t                 cfg
);

  logic [sobol_gen_pkg::DIMS_W-1:0] dims_r, dims_nxt;
  logic [31:0]                      run_len_r, run_len_nxt;
  logic                             wr_en;
  logic                             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    dims_nxt    = dims_r;
    run_len_nxt = run_len_r;
    if (wr_en) begin
      case (reg_sel)
        sobol_gen_pkg::REG_DIMS: begin
          dims_nxt = pwdata[sobol_gen_pkg::DIMS_W-1:0];
        end
        sobol_gen_pkg::REG_RUN_LEN: begin
          run_len_nxt = pwdata;
        end
        default: begin
          dims_nxt = dims_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r    <= sobol_gen_pkg::DIMS_W'(sobol_gen_pkg::MAX_DIMS);
      run_len_r <= '1;
    end else begin
      dims_r    <= dims_nxt;
      run_len_r <= run_len_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      sobol_gen_pkg::REG_DIMS: begin
        prdata = {{(sobol_gen_pkg::CFG_DATA_W - sobol_gen_pkg::DIMS_W){1'b0}}, dims_r};
      end
      sobol_gen_pkg::REG_RUN_LEN: begin
        prdata = run_len_r;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg.dims_in_use    = dims_r;
  assign cfg.points_per_run = run_len_r;

endmodule

/* design/sobol_gen_core.sv */
// Point index and running XOR state; forms the next point in one pass.
// Depends on sobol_gen_pkg for the direction-number ROM and types.
module sobol_gen_core #(
  parameter int NUM_DIMS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  restart,
  input  sobol_gen_pkg::cfg_t   cfg,
  output sobol_gen_pkg::point_t point
);

  logic [31:0]                         next_index_r, next_index_nxt;
  logic [31:0]                         idx_cur;
  logic [sobol_gen_pkg::DIR_IDX_W-1:0] dir_sel;
  logic                                step;
  logic                                last;
  sobol_gen_pkg::frac_t                coord_w [sobol_gen_pkg::MAX_DIMS];

  assign idx_cur = restart ? '0 : next_index_r;
  assign step    = |idx_cur;
  assign last    = ({1'b0, idx_cur} + 33'd1) >= {1'b0, cfg.points_per_run};

  // trailing zeros of n equal trailing ones of n-1
  always_comb begin
    dir_sel = '0;
    for (int b = sobol_gen_pkg::FRACTION_BITS - 1; b >= 0; b--) begin
      if (idx_cur[b]) dir_sel = sobol_gen_pkg::DIR_IDX_W'(b);
    end
  end

  assign next_index_nxt = last ? '0 : idx_cur + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r <= '0;
    end else if (advance) begin
      next_index_r <= next_index_nxt;
    end
  end

  for (genvar gd = 0; gd < sobol_gen_pkg::MAX_DIMS; gd++) begin : g_dim
    if (gd < NUM_DIMS) begin : g_live
      sobol_gen_pkg::frac_t run_r;
      sobol_gen_pkg::frac_t run_base;
      sobol_gen_pkg::frac_t run_new;
      logic                 active;

      assign run_base = restart ? '0 : run_r;
      assign run_new  = run_base ^ (step ? sobol_gen_pkg::DIR_ROM[gd][dir_sel] : '0);
      assign active   = cfg.dims_in_use > sobol_gen_pkg::DIMS_W'(gd);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r <= '0;
        end else if (advance) begin
          run_r <= last ? '0 : run_new;
        end
      end

      assign coord_w[gd] = active ? run_new : '0;
    end else begin : g_off
      assign coord_w[gd] = '0;
    end
  end

  always_comb begin
    point.point_index = idx_cur;
    point.last_point  = last;
    for (int d = 0; d < sobol_gen_pkg::MAX_DIMS; d++) point.coord[d] = coord_w[d];
  end

endmodule

/* design/sobol_sequence_generator_top.sv */
// Top level of the Gray-code Sobol point generator.
// Instantiates sobol_gen_cfg and sobol_gen_core; depends on sobol_gen_pkg.
//
// Usage:
//   Each word accepted on the in_ channel (in_valid high, in_stall low) asks
//   for the next point; in_restart high starts the run over at point 0.
//   Each request yields exactly one word on the out_ channel: the point
//   index, a last-point flag and eight unsigned 0.32 coordinates.
//   A request passes through the input register, then the index/XOR update
//   into the result register, where out_valid rises.
//   Throughput is one point per cycle while out_stall is low, set by the
//   update of the index and running coordinate registers.
//   The input register takes one more word while a result sits stalled at
//   the output; in_stall rises only when both registers are full and
//   out_stall is high. A stalled result holds its payload.
//   Reset clears the valid flags of both pipeline registers, the run index
//   and the running coordinates, and restores eight dimensions and the maximum run length.
//   Write the APB registers only while no request is in flight.
module sobol_sequence_generator_top #(
  parameter int NUM_DIMS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          out_point_index,
  output logic                                 out_last_point,
  output logic [31:0]                          out_coord_0,
  output logic [31:0]                          out_coord_1,
  output logic [31:0]                          out_coord_2,
  output logic [31:0]                          out_coord_3,
  output logic [31:0]                          out_coord_4,
  output logic [31:0]                          out_coord_5,
  output logic [31:0]                          out_coord_6,
  output logic [31:0]                          out_coord_7,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sobol_gen_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sobol_gen_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sobol_gen_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  sobol_gen_pkg::cfg_t   cfg;
  sobol_gen_pkg::point_t point;
  sobol_gen_pkg::point_t out_r;

  logic in_valid_r, in_valid_nxt;
  logic restart_r;
  logic out_valid_r, out_valid_nxt;
  logic in_take;
  logic out_load;

  sobol_gen_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sobol_gen_core #(
    .NUM_DIMS (NUM_DIMS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (out_load),
    .restart (restart_r),
    .cfg     (cfg),
    .point   (point)
  );

  assign out_load      = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = in_valid_r & ~out_load;
  assign in_take       = in_valid & ~in_stall;
  assign in_valid_nxt  = in_take | (in_valid_r & ~out_load);
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      restart_r <= in_restart;
    end
    if (out_load) begin
      out_r <= point;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_r.point_index;
  assign out_last_point  = out_r.last_point;
  assign out_coord_0     = out_r.coord[0];
  assign out_coord_1     = out_r.coord[1];
  assign out_coord_2     = out_r.coord[2];
  assign out_coord_3     = out_r.coord[3];
  assign out_coord_4     = out_r.coord[4];
  assign out_coord_5     = out_r.coord[5];
  assign out_coord_6     = out_r.coord[6];
  assign out_coord_7     = out_r.coord[7];

endmodule

/* design/sobol_gen_checker.sv */
// Port-level checks for the Sobol generator, bound to the top level.
// Depends on sobol_sequence_generator_top_macros.svh.
`include "sobol_sequence_generator_top_macros.svh"

module sobol_gen_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_point_index,
  input logic [31:0] out_coord_0,
  input logic [31:0] out_coord_1,
  input logic [31:0] out_coord_2,
  input logic [31:0] out_coord_3,
  input logic [31:0] out_coord_4,
  input logic [31:0] out_coord_5,
  input logic [31:0] out_coord_6,
  input logic [31:0] out_coord_7
);

  logic coords_zero;

  assign coords_zero = (out_coord_0 == 32'd0) && (out_coord_1 == 32'd0) &&
                       (out_coord_2 == 32'd0) && (out_coord_3 == 32'd0) &&
                       (out_coord_4 == 32'd0) && (out_coord_5 == 32'd0) &&
                       (out_coord_6 == 32'd0) && (out_coord_7 == 32'd0);

  `SOBOL_ASSERT_RST(a_reset_empty, !out_valid)
  `SOBOL_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid)
  `SOBOL_ASSERT_NEXT(a_stall_index, out_valid && out_stall, $stable(out_point_index))
  `SOBOL_ASSERT_NOW(a_origin_zero, out_valid && (out_point_index == 32'd0), coords_zero)

endmodule

bind sobol_sequence_generator_top sobol_gen_checker u_sobol_gen_checker (.*);

/* tb/sobol_sequence_generator_top_tb.sv */
// Self-checking testbench for the Gray-code Sobol point generator top level.
// Drives requests and APB register writes, predicts each point and checks it.
// Depends on sobol_gen_pkg and sobol_sequence_generator_top.
module sobol_sequence_generator_top_tb;

  localparam int N_DIMS = 8;
  localparam int FRAC_W = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 108;

  localparam logic [sobol_gen_pkg::CFG_ADDR_W-1:0] ADDR_DIMS =
    {sobol_gen_pkg::REG_DIMS, 2'b00};
  localparam logic [sobol_gen_pkg::CFG_ADDR_W-1:0] ADDR_RUN_LEN =
    {sobol_gen_pkg::REG_RUN_LEN, 2'b00};

  localparam int POLY_DEGREE [N_DIMS] = '{0, 1, 2, 3, 3, 4, 4, 5};
  localparam int POLY_TAPS   [N_DIMS] = '{0, 0, 1, 1, 2, 1, 4, 2};
  localparam int POLY_SEED   [N_DIMS][5] = '{
    '{1, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0},
    '{1, 3, 0, 0, 0},
    '{1, 3, 1, 0, 0},
    '{1, 1, 1, 0, 0},
    '{1, 1, 3, 3, 0},
    '{1, 3, 5, 13, 0},
    '{1, 1, 5, 5, 17}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_point_index;
  logic out_last_point;
  logic [31:0] out_coord_0, out_coord_1, out_coord_2, out_coord_3;
  logic [31:0] out_coord_4, out_coord_5, out_coord_6, out_coord_7;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sobol_gen_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [sobol_gen_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [sobol_gen_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  logic [FRAC_W-1:0] direction [N_DIMS][FRAC_W+1];
  logic [FRAC_W-1:0] seq_coords [N_DIMS];
  logic [31:0] seq_index;
  logic [3:0] cfg_dims;
  logic [31:0] cfg_run_len;

  logic restart_queue [$];
  sobol_gen_pkg::point_t points_due [$];

  logic quiet = 1'b0;
  logic hold = 1'b0;
  int fail_count = 0;
  int idle_cycles = 0;
  int deg;
  logic [FRAC_W-1:0] dir_word;
  logic [3:0] rnd_dims;
  logic [31:0] rnd_len;
  int restart_pct;

  always #5 clk = ~clk;

  sobol_sequence_generator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_point_index(out_point_index),
    .out_last_point(out_last_point),
    .out_coord_0(out_coord_0),
    .out_coord_1(out_coord_1),
    .out_coord_2(out_coord_2),
    .out_coord_3(out_coord_3),
    .out_coord_4(out_coord_4),
    .out_coord_5(out_coord_5),
    .out_coord_6(out_coord_6),
    .out_coord_7(out_coord_7),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  function automatic sobol_gen_pkg::point_t next_point(logic restart);
    sobol_gen_pkg::point_t pt;
    logic [31:0] t;
    int c;
    if (restart) begin
      seq_index = '0;
      seq_coords = '{default: '0};
    end
    if (seq_index != 0) begin
      t = seq_index - 32'd1;
      c = 1;
      while (t[0] && c < FRAC_W) begin
        t = t >> 1;
        c++;
      end
      for (int d = 0; d < N_DIMS; d++) seq_coords[d] ^= direction[d][c];
    end
    pt.point_index = seq_index;
    pt.last_point = ({1'b0, seq_index} + 33'd1) >= {1'b0, cfg_run_len};
    for (int d = 0; d < N_DIMS; d++)
      pt.coord[d] = (d < cfg_dims) ? seq_coords[d] : '0;
    if (pt.last_point) begin
      seq_index = '0;
      seq_coords = '{default: '0};
    end else begin
      seq_index = seq_index + 32'd1;
    end
    return pt;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_restart <= 1'b0;
    end else begin
      if (in_valid && !in_stall) points_due.push_back(next_point(in_restart));
      if (!in_valid || !in_stall) begin
        if (restart_queue.size() != 0 && !hold &&
            !(!quiet && $urandom_range(0, 99) < 12)) begin
          in_valid <= 1'b1;
          in_restart <= restart_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_restart <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    sobol_gen_pkg::point_t got;
    sobol_gen_pkg::point_t want;
    logic bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.point_index = out_point_index;
        got.last_point = out_last_point;
        got.coord[0] = out_coord_0;
        got.coord[1] = out_coord_1;
        got.coord[2] = out_coord_2;
        got.coord[3] = out_coord_3;
        got.coord[4] = out_coord_4;
        got.coord[5] = out_coord_5;
        got.coord[6] = out_coord_6;
        got.coord[7] = out_coord_7;
        if (points_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unrequested point word: idx %0d last %0b coords %h",
                     got.point_index, got.last_point, got.coord);
        end else begin
          want = points_due.pop_front();
          bad = (got.point_index !== want.point_index) ||
                (got.last_point !== want.last_point);
          for (int d = 0; d < N_DIMS; d++)
            if (got.coord[d] !== want.coord[d]) bad = 1'b1;
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp idx %0d last %0b coords %h, got idx %0d last %0b coords %h",
                       want.point_index, want.last_point, want.coord,
                       got.point_index, got.last_point, got.coord);
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 12);
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sobol_sequence_generator_top_tb failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [sobol_gen_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_DIMS) cfg_dims = data[3:0];
    else cfg_run_len = data;
  endtask

  task automatic configure(logic [3:0] dims, logic [31:0] len);
    write_reg(ADDR_DIMS, {28'd0, dims});
    write_reg(ADDR_RUN_LEN, len);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (restart_queue.size() != 0 || in_valid || points_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    for (int d = 0; d < N_DIMS; d++) begin
      deg = POLY_DEGREE[d];
      for (int i = 0; i <= FRAC_W; i++) direction[d][i] = '0;
      if (d == 0) begin
        for (int i = 1; i <= FRAC_W; i++) direction[d][i] = 32'd1 << (FRAC_W - i);
      end else begin
        for (int i = 1; i <= deg; i++)
          direction[d][i] = 32'(POLY_SEED[d][i-1]) << (FRAC_W - i);
        for (int i = deg + 1; i <= FRAC_W; i++) begin
          dir_word = direction[d][i-deg] ^ (direction[d][i-deg] >> deg);
          for (int j = 1; j + 1 <= deg; j++)
            if (((POLY_TAPS[d] >> (deg - 1 - j)) & 1) != 0)
              dir_word = dir_word ^ direction[d][i-j];
          direction[d][i] = dir_word;
        end
      end
    end
    seq_index = '0;
    seq_coords = '{default: '0};
    cfg_dims = 4'd8;
    cfg_run_len = 32'hFFFF_FFFF;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, restart in mid-run
    @(negedge clk);
    restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    wait_drained();
    // no active dimensions, zero run length
    configure(4'd0, 32'd0);
    restart_queue = '{1'b0, 1'b0, 1'b1};
    wait_drained();
    // dimension count above eight, run of one
    configure(4'd15, 32'd1);
    restart_queue = '{1'b0, 1'b1};
    wait_drained();
    // short run wraps, then restart
    configure(4'd3, 32'd5);
    restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    wait_drained();
    // dimension count and run length changed in mid-run
    configure(4'd8, 32'hFFFF_FFFF);
    restart_queue = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    wait_drained();
    write_reg(ADDR_DIMS, 32'd2);
    restart_queue = '{1'b0, 1'b0};
    wait_drained();
    write_reg(ADDR_RUN_LEN, 32'd3);
    restart_queue = '{1'b0, 1'b0};
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          rnd_dims = 4'd8;
          rnd_len = 32'hFFFF_FFFF;
        end
        1: begin
          rnd_dims = 4'd1;
          rnd_len = 32'd0;
        end
        2: begin
          rnd_dims = 4'd0;
          rnd_len = 32'd1;
        end
        3: begin
          rnd_dims = 4'd15;
          rnd_len = $urandom;
        end
        default: begin
          rnd_dims = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8))
                                                 : 4'($urandom_range(0, 15));
          case ($urandom_range(0, 9))
            6: rnd_len = 32'd0;
            7: rnd_len = $urandom_range(100, 400);
            8: rnd_len = 32'hFFFF_FFFF;
            9: rnd_len = $urandom;
            default: rnd_len = $urandom_range(1, 64);
          endcase
        end
      endcase
      configure(rnd_dims, rnd_len);
      restart_pct = (p == 7) ? 30 : 2;
      @(negedge clk);
      quiet = (p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++)
        restart_queue.push_back($urandom_range(0, 99) < restart_pct);
      if (p == 4) begin
        do @(negedge clk);
        while (restart_queue.size() > PHASE_ITEMS / 2);
        hold = 1'b1;
        do @(negedge clk);
        while (in_valid || points_due.size() != 0);
        hold = 1'b0;
      end
      wait_drained();
      quiet = 1'b0;
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && points_due.size() == 0) begin
      $display("sobol_sequence_generator_top_tb passed");
    end else begin
      $display("sobol_sequence_generator_top_tb failed");
    end
    $finish;
  end

endmodule
